// ===== sv/matrix3_inverse_assert.svh =====
// Assertion macros for the matrix inverse back end.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// Same-cycle implication on i_clk, off while i_rst_n is low.
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, off while i_rst_n is low.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mi3_pkg.sv =====
// Types and constants of the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;
    localparam int MW   = 32;   // input entry width
    localparam int PW   = 64;   // exact product of two entries
    localparam int AW   = 65;   // signed cofactor, Q32.32
    localparam int MAGW = 64;   // cofactor magnitude
    localparam int TW   = 96;   // magnitude of one determinant term
    localparam int DW   = 98;   // signed determinant, Q48.48
    localparam int DMW  = 97;   // determinant magnitude
    localparam int QB   = 32;   // quotient bits, one per divider stage
    localparam int NENT = 9;    // entries per matrix
    localparam int IDXW = 4;
    localparam int NFS  = 6;    // front pipeline depth

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NENT - 1);
    localparam logic [MW-1:0]   POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [MW-1:0]   NEG_MIN  = 32'h8000_0000;

    typedef struct packed {
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m20;
        logic signed [MW-1:0] m21;
        logic signed [MW-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [MW-1:0] inv00;
        logic signed [MW-1:0] inv01;
        logic signed [MW-1:0] inv02;
        logic signed [MW-1:0] inv10;
        logic signed [MW-1:0] inv11;
        logic signed [MW-1:0] inv12;
        logic signed [MW-1:0] inv20;
        logic signed [MW-1:0] inv21;
        logic signed [MW-1:0] inv22;
        logic                 singular;
        logic                 saturated;
    } t_inv;

    // One classified matrix: adjugate in output order, |det|, its sign and a singular flag.
    typedef struct packed {
        logic [NENT-1:0][AW-1:0] adj;
        logic [DMW-1:0]          dmag;
        logic                    dneg;
        logic                    sing;
    } t_job;

    // One entry in flight through the divider.
    typedef struct packed {
        logic            vld;
        logic [DMW-1:0]  rem;
        logic [DMW-1:0]  dvs;
        logic [QB-1:0]   quo;
        logic            neg;
        logic            presat;
        logic            sing;
        logic [IDXW-1:0] idx;
    } t_div;
endpackage
`default_nettype wire

// ===== sv/mi3_front.sv =====
// Front pipeline: cofactors and determinant of each accepted matrix.
`default_nettype none
module mi3_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mi3_pkg::t_mat i_mat,
    output logic               o_job_valid,
    input  wire logic          i_job_ready,
    output mi3_pkg::t_job      o_job
);
    import mi3_pkg::*;

    function automatic logic signed [PW-1:0] smul(logic signed [MW-1:0] a,
                                                  logic signed [MW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    logic [NFS-1:0] r_v;
    logic           en;

    logic signed [PW-1:0] r1_p [18];
    logic [MW-1:0]        r1_m0 [3];
    logic [MW-1:0]        r2_m0 [3];
    logic [AW-1:0]        r2_adj [NENT];
    logic [AW-1:0]        r3_adj [NENT];
    logic [AW-1:0]        r4_adj [NENT];
    logic [AW-1:0]        r5_adj [NENT];
    logic [PW-1:0]        r3_lo [3];
    logic [PW-1:0]        r3_hi [3];
    logic [2:0]           r3_sn;
    logic [DW-1:0]        r4_t [3];
    logic [DW-1:0]        r5_det;
    t_job                 r6_job;

    logic [MW-1:0]   n_mabs [3];
    logic [MAGW-1:0] n_amag [3];
    logic [TW-1:0]   n_tmag [3];

    assign en          = !r_v[NFS-1] || i_job_ready;
    assign o_ready     = en;
    assign o_job_valid = r_v[NFS-1];
    assign o_job       = r6_job;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_mabs[c] = r2_m0[c][MW-1] ? MW'(~r2_m0[c] + 1'b1) : r2_m0[c];
            n_amag[c] = r2_adj[3*c][AW-1] ? MAGW'(~r2_adj[3*c] + 1'b1)
                                          : MAGW'(r2_adj[3*c]);
            n_tmag[c] = {r3_hi[c], 32'b0} + TW'(r3_lo[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NFS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0]  <= smul(i_mat.m11, i_mat.m22);
            r1_p[1]  <= smul(i_mat.m21, i_mat.m12);
            r1_p[2]  <= smul(i_mat.m21, i_mat.m02);
            r1_p[3]  <= smul(i_mat.m01, i_mat.m22);
            r1_p[4]  <= smul(i_mat.m01, i_mat.m12);
            r1_p[5]  <= smul(i_mat.m11, i_mat.m02);
            r1_p[6]  <= smul(i_mat.m20, i_mat.m12);
            r1_p[7]  <= smul(i_mat.m10, i_mat.m22);
            r1_p[8]  <= smul(i_mat.m00, i_mat.m22);
            r1_p[9]  <= smul(i_mat.m20, i_mat.m02);
            r1_p[10] <= smul(i_mat.m10, i_mat.m02);
            r1_p[11] <= smul(i_mat.m00, i_mat.m12);
            r1_p[12] <= smul(i_mat.m10, i_mat.m21);
            r1_p[13] <= smul(i_mat.m20, i_mat.m11);
            r1_p[14] <= smul(i_mat.m20, i_mat.m01);
            r1_p[15] <= smul(i_mat.m00, i_mat.m21);
            r1_p[16] <= smul(i_mat.m00, i_mat.m11);
            r1_p[17] <= smul(i_mat.m10, i_mat.m01);
            r1_m0[0] <= i_mat.m00;
            r1_m0[1] <= i_mat.m01;
            r1_m0[2] <= i_mat.m02;
            for (int e = 0; e < NENT; e++) begin
                r2_adj[e] <= AW'(r1_p[2*e]) - AW'(r1_p[2*e+1]);
                r3_adj[e] <= r2_adj[e];
                r4_adj[e] <= r3_adj[e];
                r5_adj[e] <= r4_adj[e];
                r6_job.adj[e] <= r5_adj[e];
            end
            for (int c = 0; c < 3; c++) begin
                r2_m0[c] <= r1_m0[c];
                r3_lo[c] <= PW'(n_mabs[c]) * PW'(n_amag[c][31:0]);
                r3_hi[c] <= PW'(n_mabs[c]) * PW'(n_amag[c][MAGW-1:32]);
                r3_sn[c] <= r2_m0[c][MW-1] ^ r2_adj[3*c][AW-1];
                r4_t[c]  <= r3_sn[c] ? DW'(DW'(0) - DW'(n_tmag[c])) : DW'(n_tmag[c]);
            end
            r5_det      <= r4_t[0] + r4_t[1] + r4_t[2];
            r6_job.dneg <= r5_det[DW-1];
            r6_job.dmag <= DMW'(r5_det[DW-1] ? (DW'(0) - r5_det) : r5_det);
            r6_job.sing <= (r5_det == '0);
        end
    end
endmodule
`default_nettype wire

// ===== sv/mi3_queue.sv =====
// Two-entry queue of classified matrices between front and back.
`default_nettype none
module mi3_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mi3_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mi3_pkg::t_job      o_job
);
    import mi3_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

// ===== sv/mi3_back.sv =====
// Back end: issue nine entries per matrix into a 32-stage divider, gather results.
`default_nettype none
`include "matrix3_inverse_assert.svh"
module mi3_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  wire mi3_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mi3_pkg::t_inv      o_inv
);
    import mi3_pkg::*;

    t_div            r_dv [QB+1];
    logic [IDXW-1:0] r_idx;
    logic [MW-1:0]   r_asm [8];
    logic            r_asat;
    t_inv            r_out;
    logic            r_o_valid;

    logic            adv;
    logic            issue;
    logic            done;
    t_div            tail;
    logic [AW-1:0]   sel_adj;
    logic [MAGW-1:0] sel_mag;
    logic [MW-1:0]   n_val;
    logic            n_sat;

    assign tail        = r_dv[QB];
    assign done        = tail.vld && (tail.idx == LAST_IDX);
    assign adv         = !(r_o_valid && !i_ready && done);
    assign issue       = i_job_valid && adv;
    assign o_job_ready = adv && (r_idx == LAST_IDX);
    assign o_valid     = r_o_valid;
    assign o_inv       = r_out;
    assign sel_adj     = i_job.adj[r_idx];
    assign sel_mag     = sel_adj[AW-1] ? MAGW'(~sel_adj + 1'b1) : MAGW'(sel_adj);

    // Saturate the quotient and apply the sign; a singular matrix gives zero.
    always_comb begin
        n_val = tail.quo;
        n_sat = 1'b0;
        if (tail.presat || (tail.neg ? (tail.quo > NEG_MIN) : (tail.quo > POS_MAX))) begin
            n_val = tail.neg ? NEG_MIN : POS_MAX;
            n_sat = 1'b1;
        end else if (tail.neg) begin
            n_val = MW'(~tail.quo + 1'b1);
        end
        if (tail.sing) begin
            n_val = '0;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (adv) begin
            r_dv[0].vld    <= issue;
            r_dv[0].rem    <= DMW'(sel_mag);
            r_dv[0].dvs    <= i_job.dmag;
            r_dv[0].quo    <= '0;
            r_dv[0].neg    <= sel_adj[AW-1] ^ i_job.dneg;
            r_dv[0].presat <= (DMW'(sel_mag) >= i_job.dmag);
            r_dv[0].sing   <= i_job.sing;
            r_dv[0].idx    <= r_idx;
        end
    end

    // One quotient bit per stage: shift, compare, subtract.
    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [DMW:0] two;
        logic         ge;
        t_div         n_dv;
        assign two = {r_dv[k-1].rem, 1'b0};
        assign ge  = (two >= {1'b0, r_dv[k-1].dvs});
        always_comb begin
            n_dv     = r_dv[k-1];
            n_dv.rem = ge ? DMW'(two - {1'b0, r_dv[k-1].dvs}) : DMW'(two);
            n_dv.quo = {r_dv[k-1].quo[QB-2:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].vld <= 1'b0;
            end else if (adv) begin
                r_dv[k] <= n_dv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv && done) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && tail.vld) begin
            if (tail.idx == LAST_IDX) begin
                r_out.inv00     <= r_asm[0];
                r_out.inv01     <= r_asm[1];
                r_out.inv02     <= r_asm[2];
                r_out.inv10     <= r_asm[3];
                r_out.inv11     <= r_asm[4];
                r_out.inv12     <= r_asm[5];
                r_out.inv20     <= r_asm[6];
                r_out.inv21     <= r_asm[7];
                r_out.inv22     <= n_val;
                r_out.singular  <= tail.sing;
                r_out.saturated <= r_asat || n_sat;
            end else begin
                r_asm[tail.idx[2:0]] <= n_val;
                r_asat <= (tail.idx == '0) ? n_sat : (r_asat || n_sat);
            end
        end
    end

    `MI3_ASSERT_NOW(a_idx_range, 1'b1, r_idx <= LAST_IDX, "issue index out of range")
    `MI3_ASSERT_NEXT(a_out_load, adv && done, r_o_valid, "finished matrix not presented")
    `MI3_ASSERT_NOW(a_sing_zero, r_o_valid && r_out.singular, !r_out.saturated && r_out.inv00 == '0, "singular result not cleared")
endmodule
`default_nettype wire

// ===== sv/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse, adjugate over determinant.
`default_nettype none
// Inverse of a 3x3 matrix of signed Q16.16 entries. Cofactors are formed
// exactly (Q32.32) and the determinant exactly (Q48.48) in a six-stage front
// pipeline; each result entry is the transposed cofactor times 2^32 over the
// determinant, truncated toward zero and saturated to 32 bits, with the
// saturated flag set if any entry clipped. A zero determinant gives all-zero
// entries and the singular flag. The nine entries of a matrix share one
// 32-stage pipelined divider that takes one entry per cycle while the output
// is not stalled. The front accepts a new matrix every cycle until the
// two-entry queue ahead of the divider fills, so bursts are absorbed. Each
// matrix passes the front, the queue and the divider; the result sits in an
// output register, so the divider keeps working while it waits.
module matrix3_inverse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mi3_pkg::t_mat i_mat,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mi3_pkg::t_inv      o_inv
);
    import mi3_pkg::*;

    // front -> queue
    logic f_valid;
    logic f_ready;
    t_job f_job;
    // queue -> back
    logic b_valid;
    logic b_ready;
    t_job b_job;

    // Classify: cofactors, determinant, singular check.
    mi3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mat       (i_mat),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // Hold up to two matrices so front and back stall independently.
    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_job   (b_job)
    );

    // Divide each cofactor by the determinant and assemble the item.
    mi3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .i_job       (b_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_inv       (o_inv)
    );
endmodule
`default_nettype wire
